// File: hw/rtl/stbs_pkg.sv
package stbs_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned POS_W  = 10;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic [POS_W-1:0]        position;
    logic signed [KEY_W-1:0] key_echo;
    logic                    table_full;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch key, set up insert place and search bounds
    logic clear_cnt;  // empty the table
    logic rd_ins;     // read the entry below the insert place
    logic rd_q;       // read the search midpoint and keep it
    logic wr_shift;   // move the entry read up by one place
    logic wr_key;     // write the key at the insert place, count one more
    logic q_lo;       // search continues above the midpoint
    logic q_hi;       // search continues below the midpoint
    logic finish;     // present a result
    logic res_hit;
    logic res_full;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic place_zero;
    logic range_empty;
    logic key_lt;
    logic key_gt;
  } sts_t;

endpackage

// File: hw/rtl/stbs_ram.sv
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/stbs_ctrl.sv
module stbs_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [stbs_pkg::KIND_W-1:0]  kind,
  input  stbs_pkg::sts_t               sts,
  output stbs_pkg::cmd_t               cmd,
  output logic                         busy
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_RD  = 3'd1;
  localparam logic [2:0] ST_INS_CMP = 3'd2;
  localparam logic [2:0] ST_Q_RD    = 3'd3;
  localparam logic [2:0] ST_Q_CMP   = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (kind == stbs_pkg::KIND_INSERT) begin
            state_nxt = ST_INS_RD;
          end else if (kind == stbs_pkg::KIND_QUERY) begin
            state_nxt = ST_Q_RD;
          end else begin
            cmd.clear_cnt = (kind == stbs_pkg::KIND_CLEAR);
            state_nxt     = ST_DONE;
          end
        end
      end
      // The count only changes when the key lands, so full is checked on each
      // pass through this state and stays false while entries shift.
      ST_INS_RD: begin
        if (sts.full) begin
          cmd.finish   = 1'b1;
          cmd.res_full = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (sts.place_zero) begin
          cmd.wr_key = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.rd_ins = 1'b1;
          state_nxt  = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts.key_lt) begin
          cmd.wr_shift = 1'b1;
          state_nxt    = ST_INS_RD;
        end else begin
          cmd.wr_key = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_Q_RD: begin
        if (sts.range_empty) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.rd_q  = 1'b1;
          state_nxt = ST_Q_CMP;
        end
      end
      ST_Q_CMP: begin
        if (sts.key_lt) begin
          cmd.q_hi  = 1'b1;
          state_nxt = ST_Q_RD;
        end else if (sts.key_gt) begin
          cmd.q_lo  = 1'b1;
          state_nxt = ST_Q_RD;
        end else begin
          cmd.finish  = 1'b1;
          cmd.res_hit = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: hw/rtl/stbs_dpath.sv
module stbs_dpath #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stbs_pkg::in_item_t   in_data,
  input  stbs_pkg::cmd_t       cmd,
  output stbs_pkg::sts_t       sts,
  output logic                 out_valid,
  output stbs_pkg::out_item_t  out_data
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  logic [CW-1:0]                     count_r;
  logic [CW-1:0]                     place_r;
  logic [CW-1:0]                     lo_r;
  logic [CW-1:0]                     hi1_r;   // one past the upper bound
  logic [IW-1:0]                     mid_r;
  logic signed [stbs_pkg::KEY_W-1:0] key_r;
  logic                              out_valid_r;
  stbs_pkg::out_item_t               out_data_r;

  logic [CW:0]                       mid_sum;
  logic [IW-1:0]                     mid_nxt;
  logic [IW-1:0]                     place_dn;
  logic                              ram_we;
  logic [IW-1:0]                     ram_waddr;
  logic [stbs_pkg::KEY_W-1:0]        ram_wdata;
  logic                              ram_re;
  logic [IW-1:0]                     ram_raddr;
  logic [stbs_pkg::KEY_W-1:0]        ram_rdata;
  logic signed [stbs_pkg::KEY_W-1:0] probe;

  // Midpoint is floor((lo + hi) / 2); only used while lo <= hi.
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi1_r} - (CW+1)'(1);
  assign mid_nxt  = IW'(mid_sum >> 1);
  assign place_dn = IW'(place_r - CW'(1));

  assign ram_we    = cmd.wr_shift | cmd.wr_key;
  assign ram_waddr = IW'(place_r);
  assign ram_wdata = cmd.wr_shift ? ram_rdata : key_r;
  assign ram_re    = cmd.rd_ins | cmd.rd_q;
  assign ram_raddr = cmd.rd_q ? mid_nxt : place_dn;

  stbs_ram #(
    .WIDTH (stbs_pkg::KEY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign probe = $signed(ram_rdata);

  assign sts.full        = (count_r == CW'(TABLE_ENTRIES));
  assign sts.place_zero  = (place_r == '0);
  assign sts.range_empty = (lo_r >= hi1_r);
  assign sts.key_lt      = (key_r < probe);
  assign sts.key_gt      = (key_r > probe);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_cnt) begin
        count_r <= '0;
      end else if (cmd.wr_key) begin
        count_r <= count_r + CW'(1);
      end
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= in_data.value;
      place_r <= count_r;
      lo_r    <= '0;
      hi1_r   <= count_r;
    end else begin
      if (cmd.wr_shift) begin
        place_r <= place_r - CW'(1);
      end
      if (cmd.q_lo) begin
        lo_r <= CW'(mid_r) + CW'(1);
      end
      if (cmd.q_hi) begin
        hi1_r <= CW'(mid_r);
      end
    end
    if (cmd.rd_q) begin
      mid_r <= mid_nxt;
    end
    if (cmd.finish) begin
      out_data_r.hit        <= cmd.res_hit;
      out_data_r.position   <= cmd.res_hit ? stbs_pkg::POS_W'(mid_r) : '0;
      out_data_r.key_echo   <= key_r;
      out_data_r.table_full <= cmd.res_full;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/sorted_table_binary_search.sv
// Sorted key table with binary-search membership queries.
// Input: when busy is low, raise start for one cycle with in_data; the item
// is taken at that edge and busy rises until the result is issued.
// in_data.kind selects clear, insert or query; any other kind only echoes.
// Output: exactly one result per item, shown for one cycle with out_valid.
// The receiver cannot stall; out_data must be captured on the strobe.
// A clear or an unused kind goes straight to its result. A query ends on
// the first probe that matches (a hit) or when the search range is empty
// (a miss). An insert moves each larger entry up by one place and then
// writes the key; an insert is dropped, with table_full set, when the table
// is full. Each probe and each shifted entry is one read of the single
// table RAM, then a compare on the registered read data.
// A new item can be accepted in the cycle the previous result is shown.
// Reset empties the table (count to zero); stored keys need no clearing.
// A query reports the first probe that matches when keys repeat.
module sorted_table_binary_search #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  stbs_pkg::in_item_t  in_data,
  output logic                out_valid,
  output stbs_pkg::out_item_t out_data
);

  stbs_pkg::cmd_t cmd;
  stbs_pkg::sts_t sts;

  stbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_data.kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  stbs_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/stbs_checker.sv
module stbs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input stbs_pkg::out_item_t out_data
);

  // An accepted item raises busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // A result only follows a cycle spent working on an item.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item in progress");

  // Results never come in adjacent cycles.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in adjacent cycles");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.position == '0)
    else $error("position set without a hit");

  a_hit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> !out_data.table_full)
    else $error("hit and table_full together");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
